// ----- sv/ftoa_pkg.sv -----
// Package: shared types, character codes and the fraction digit table.
`default_nettype none
package ftoa_pkg;

    localparam int RAW_W   = 16;
    localparam int CHAR_W  = 7;
    localparam int WHOLE_W = 12;
    localparam int FRAC_W  = 4;
    localparam int NDIG    = 4;

    localparam logic [RAW_W-1:0]  SIGN_MASK = 16'h8000;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 7'h2E;

    // One conversion job handed from the front to the back.
    typedef struct packed {
        logic                  sign;
        logic [NDIG-1:0][3:0]  digits;  // BCD of the integer part, digit 0 is units
        logic [2:0]            ndig;    // significant integer digits, 1..4
        logic [FRAC_W-1:0]     frac;    // sixteenths
    } job_t;

    // Sixteenths times 625, as four BCD digits.
    function automatic logic [15:0] frac_bcd(input logic [FRAC_W-1:0] f);
        case (f)
            4'd0:    frac_bcd = 16'h0000;
            4'd1:    frac_bcd = 16'h0625;
            4'd2:    frac_bcd = 16'h1250;
            4'd3:    frac_bcd = 16'h1875;
            4'd4:    frac_bcd = 16'h2500;
            4'd5:    frac_bcd = 16'h3125;
            4'd6:    frac_bcd = 16'h3750;
            4'd7:    frac_bcd = 16'h4375;
            4'd8:    frac_bcd = 16'h5000;
            4'd9:    frac_bcd = 16'h5625;
            4'd10:   frac_bcd = 16'h6250;
            4'd11:   frac_bcd = 16'h6875;
            4'd12:   frac_bcd = 16'h7500;
            4'd13:   frac_bcd = 16'h8125;
            4'd14:   frac_bcd = 16'h8750;
            default: frac_bcd = 16'h9375;
        endcase
    endfunction

    // Fraction digit at position pos, 0 is the tenths digit.
    function automatic logic [3:0] frac_digit(input logic [FRAC_W-1:0] f,
                                              input logic [1:0] pos);
        logic [15:0] w;
        w = frac_bcd(f);
        case (pos)
            2'd0:    frac_digit = w[15:12];
            2'd1:    frac_digit = w[11:8];
            2'd2:    frac_digit = w[7:4];
            default: frac_digit = w[3:0];
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO + {3'b000, d};
    endfunction

endpackage
`default_nettype wire

// ----- sv/ftoa_temp_if.sv -----
// Interface: input channel carrying one raw temperature word per item.
`default_nettype none
interface ftoa_temp_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;

    modport source (output valid, output raw_temperature, input ready);
    modport sink   (input valid, input raw_temperature, output ready);
endinterface
`default_nettype wire

// ----- sv/ftoa_char_if.sv -----
// Interface: output channel carrying one ASCII character per item.
`default_nettype none
interface ftoa_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ----- sv/ftoa_front.sv -----
// Front: accept a word, take its magnitude, convert the integer part to BCD.
`default_nettype none
module ftoa_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ftoa_temp_if.sink          sample,
    output ftoa_pkg::job_t     job,
    output logic               job_valid,
    input  wire logic          job_ready
);
    import ftoa_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

    fstate_t                 state_reg;
    logic                    sign_reg;
    logic [FRAC_W-1:0]       frac_reg;
    logic [WHOLE_W-1:0]      bin_reg;
    logic [4*NDIG-1:0]       bcd_reg;
    logic [3:0]              cnt_reg;

    logic [RAW_W-1:0]        mag;
    logic [4*NDIG-1:0]       bcd_adj;

    assign mag = sample.raw_temperature[RAW_W-1]
               ? RAW_W'(~sample.raw_temperature + 16'd1)
               : sample.raw_temperature;

    // Add three to every digit of five or more before the shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign sample.ready = (state_reg == F_IDLE);
    assign job_valid    = (state_reg == F_PUSH);

    always_comb
    begin
        job.sign   = sign_reg;
        job.digits = bcd_reg;
        job.frac   = frac_reg;
        if (bcd_reg[15:12] != 4'd0)
            job.ndig = 3'd4;
        else if (bcd_reg[11:8] != 4'd0)
            job.ndig = 3'd3;
        else if (bcd_reg[7:4] != 4'd0)
            job.ndig = 3'd2;
        else
            job.ndig = 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sign_reg  <= 1'b0;
            frac_reg  <= '0;
            bin_reg   <= '0;
            bcd_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (sample.valid)
                    begin
                        sign_reg  <= sample.raw_temperature[RAW_W-1];
                        frac_reg  <= mag[FRAC_W-1:0];
                        bin_reg   <= mag[RAW_W-1:FRAC_W];
                        bcd_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= F_CONV;
                    end
                end
                F_CONV:
                begin
                    bcd_reg <= {bcd_adj[4*NDIG-2:0], bin_reg[WHOLE_W-1]};
                    bin_reg <= {bin_reg[WHOLE_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(WHOLE_W - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    // hold the job until the queue takes it
                    if (job_ready)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/ftoa_fifo.sv -----
// Queue: two-entry job queue between front and back.
`default_nettype none
module ftoa_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ftoa_pkg::job_t     wr_data,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    output ftoa_pkg::job_t     rd_data,
    output logic               rd_valid,
    input  wire logic          rd_ready
);
    import ftoa_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/ftoa_back.sv -----
// Back: walk a job and emit its characters through an output register.
`default_nettype none
module ftoa_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ftoa_pkg::job_t     job,
    input  wire logic          job_valid,
    output logic               job_ready,
    ftoa_char_if.source        text
);
    import ftoa_pkg::*;

    typedef enum logic [1:0] {P_SIGN, P_INT, P_DOT, P_FRAC} phase_t;

    logic               busy_reg;
    job_t               job_reg;
    phase_t             phase_reg;
    logic [1:0]         idx_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  code_reg;
    logic               last_reg;
    logic               emit;

    assign job_ready      = !busy_reg;
    assign emit           = busy_reg && (!out_valid_reg || text.ready);
    assign text.valid     = out_valid_reg;
    assign text.char_code = code_reg;
    assign text.last_char = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            job_reg       <= '0;
            phase_reg     <= P_SIGN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (!busy_reg)
            begin
                if (job_valid)
                begin
                    job_reg   <= job;
                    busy_reg  <= 1'b1;
                    phase_reg <= job.sign ? P_SIGN : P_INT;
                    idx_reg   <= 2'(job.ndig - 3'd1);
                end
                if (text.ready)
                    out_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= 1'b0;
                case (phase_reg)
                    P_SIGN:
                    begin
                        code_reg  <= CH_MINUS;
                        phase_reg <= P_INT;
                    end
                    P_INT:
                    begin
                        code_reg <= digit_char(job_reg.digits[idx_reg]);
                        if (idx_reg == 2'd0)
                            phase_reg <= P_DOT;
                        else
                            idx_reg <= idx_reg - 2'd1;
                    end
                    P_DOT:
                    begin
                        code_reg  <= CH_DOT;
                        phase_reg <= P_FRAC;
                        idx_reg   <= 2'd0;
                    end
                    P_FRAC:
                    begin
                        code_reg <= digit_char(frac_digit(job_reg.frac, idx_reg));
                        if (idx_reg == 2'd3)
                        begin
                            last_reg <= 1'b1;
                            busy_reg <= 1'b0;
                        end
                        else
                            idx_reg <= idx_reg + 2'd1;
                    end
                    default:
                        phase_reg <= P_SIGN;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/fixed_point_temperature_to_ascii.sv -----
// Top level: signed Q12.4 temperature word to decimal ASCII character stream.
//
//  channel  modport  payload                    per item
//  -------  -------  -------------------------  -----------------------------
//  sample   sink     raw_temperature[15:0]      one two's complement Q12.4 word
//  text     source   char_code[6:0], last_char  one character, last on 4th frac
//
// The front takes a word and converts its integer part to BCD with a
// shift-and-add-three loop over the 12 integer bits, then pushes the job and
// takes no new word until the queue has it. The back emits 6 to 10 characters
// per word, one per cycle while text.ready stays high. Either side stalls on
// its own through the two-entry job queue; a stalled character holds in the
// output register. Reset clears all control state; no clearing pass is needed.
`default_nettype none
module fixed_point_temperature_to_ascii (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ftoa_temp_if.sink    sample,
    ftoa_char_if.source  text
);
    import ftoa_pkg::*;

    job_t  front_job;
    logic  front_valid;
    logic  front_ready;
    job_t  back_job;
    logic  back_valid;
    logic  back_ready;

    // Accept and convert words.
    ftoa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    // Decouple conversion from character output.
    ftoa_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_job),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    // Emit characters one item at a time.
    ftoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .text      (text)
    );

endmodule
`default_nettype wire

// ----- verif/fixed_point_temperature_to_ascii_tb.sv -----
// Testbench: drives raw Q12.4 temperature words and checks the ASCII text stream.
module fixed_point_temperature_to_ascii_tb;

    import ftoa_pkg::RAW_W;
    import ftoa_pkg::CHAR_W;

    localparam int RANDOM_WORDS   = 370;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int HOLDOFF_START  = 1200;
    localparam int HOLDOFF_LENGTH = 400;
    localparam int MAX_REPORTS    = 10;

    // ASCII codes the formatter may emit.
    localparam logic [CHAR_W-1:0] MINUS_SIGN    = 7'h2D;
    localparam logic [CHAR_W-1:0] DECIMAL_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO    = 7'h30;

    // One LSB of the raw word is 1/16 degree, i.e. 625 ten-thousandths.
    localparam int unsigned SIXTEENTH_WEIGHT = 625;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS_READY,
        RX_MOSTLY_READY,
        RX_MOSTLY_STALLED,
        RX_EVERY_FOURTH_LOW
    } rx_mode_t;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } text_char_t;

    typedef struct {
        logic [RAW_W-1:0] word;
        bit               drain_first;  // hold this word back until all text is out
    } sample_item_t;

    // Clock and reset; every block input has a known value from time zero.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    ftoa_temp_if sample_ch ();
    ftoa_char_if text_ch ();

    logic             drv_valid = 1'b0;
    logic [RAW_W-1:0] drv_word  = '0;
    logic             rx_ready  = 1'b0;

    assign sample_ch.valid           = drv_valid;
    assign sample_ch.raw_temperature = drv_word;
    assign text_ch.ready             = rx_ready;

    fixed_point_temperature_to_ascii DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .text   (text_ch)
    );

    sample_item_t pending_words [$];
    text_char_t   expected_chars [$];

    int fail_count     = 0;
    int words_accepted = 0;
    int negative_words = 0;
    int chars_checked  = 0;
    int cycle_count    = 0;
    int holdoff_clock  = 0;

    // ------------------------------------------------------------------
    // Text predictor: turn one raw word into the characters it must give.
    // ------------------------------------------------------------------
    function automatic void push_char(input logic [CHAR_W-1:0] code, input logic is_last);
        text_char_t c;
        c.code    = code;
        c.is_last = is_last;
        expected_chars.push_back(c);
    endfunction

    function automatic void format_temperature(input logic [RAW_W-1:0] word);
        logic [RAW_W-1:0] magnitude;
        int unsigned      whole;
        int unsigned      frac;
        int               int_digits [4];
        int               frac_digits [4];
        int               n_int;
        n_int = 0;
        frac  = 0;
        // Negate negative words; full-scale negative stays 0x8000 = 2048.0
        if (word[RAW_W-1])
        begin
            push_char(MINUS_SIGN, 1'b0);
            magnitude = ~word + 1'b1;
        end
        else
        begin
            magnitude = word;
        end
        for (int b = 0; b < 4; b++)
        begin
            if (magnitude[b])
                frac += SIXTEENTH_WEIGHT << b;
        end
        whole = {20'd0, magnitude[RAW_W-1:4]};
        // Collect integer digits units first; zero still prints one digit
        do
        begin
            int_digits[n_int] = whole % 10;
            whole             = whole / 10;
            n_int++;
        end while (whole != 0 && n_int < 4);
        for (int i = n_int - 1; i >= 0; i--)
            push_char(DIGIT_ZERO + int_digits[i][CHAR_W-1:0], 1'b0);
        push_char(DECIMAL_POINT, 1'b0);
        // Fraction always gives four digits, leading zeros kept
        frac_digits[0] = (frac / 1000) % 10;
        frac_digits[1] = (frac / 100) % 10;
        frac_digits[2] = (frac / 10) % 10;
        frac_digits[3] = frac % 10;
        for (int i = 0; i < 4; i++)
            push_char(DIGIT_ZERO + frac_digits[i][CHAR_W-1:0], i == 3);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer words in bursts of random length with random gaps.
    // Predict the text of each word at the edge where it is accepted.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_word   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!(drv_valid && !sample_ch.ready))
        begin
            // Either idle or the offered word was just taken
            if (drv_valid)
            begin
                format_temperature(drv_word);
                words_accepted++;
                if (drv_word[RAW_W-1])
                    negative_words++;
                void'(pending_words.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // End of burst: pick a gap, zero now and then
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    burst_left = $urandom_range(1, 12);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (pending_words.size() == 0 ||
                     (pending_words[0].drain_first && expected_chars.size() != 0))
            begin
                // Nothing to send, or wait until all text has been received
                drv_valid <= 1'b0;
            end
            else
            begin
                drv_valid <= 1'b1;
                drv_word  <= pending_words[0].word;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switch at random between stall patterns,
    // and drop ready for one long stretch so the block backs up.
    // ------------------------------------------------------------------
    rx_mode_t rx_mode      = RX_ALWAYS_READY;
    int       rx_mode_left = 0;
    int       rx_phase     = 0;
    logic     rx_next;

    always @(posedge clk)
    begin
        if (rst_n)
            holdoff_clock <= holdoff_clock + 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready     <= 1'b0;
            rx_mode_left = 0;
            rx_phase     = 0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 96);
            end
            else
            begin
                rx_mode_left--;
            end
            rx_phase++;
            case (rx_mode)
                RX_ALWAYS_READY:     rx_next = 1'b1;
                RX_MOSTLY_READY:     rx_next = ($urandom_range(0, 3) != 0);
                RX_MOSTLY_STALLED:   rx_next = ($urandom_range(0, 3) == 0);
                default:             rx_next = ((rx_phase % 4) != 0);
            endcase
            // Long hold-off while the sender keeps offering
            if (holdoff_clock >= HOLDOFF_START &&
                holdoff_clock < HOLDOFF_START + HOLDOFF_LENGTH)
                rx_next = 1'b0;
            rx_ready <= rx_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted character with the oldest prediction.
    // ------------------------------------------------------------------
    text_char_t want;

    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("char %0d: unexpected code %02h last %0b, nothing predicted",
                             chars_checked, text_ch.char_code, text_ch.last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (text_ch.char_code !== want.code || text_ch.last_char !== want.is_last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("char %0d: expected code %02h last %0b, got code %02h last %0b",
                                 chars_checked, want.code, want.is_last,
                                 text_ch.char_code, text_ch.last_char);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL fixed_point_temperature_to_ascii");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corner words, then random words, then drain.
    // ------------------------------------------------------------------
    function automatic void queue_word(input logic [RAW_W-1:0] word, input bit drain_first);
        sample_item_t s;
        s.word        = word;
        s.drain_first = drain_first;
        pending_words.push_back(s);
    endfunction

    // Build a word from sign, integer part and sixteenths.
    function automatic logic [RAW_W-1:0] make_word(input bit negative,
                                                   input logic [11:0] whole,
                                                   input logic [3:0] sixteenths);
        logic [RAW_W-1:0] m;
        m = {whole, sixteenths};
        return negative ? (~m + 1'b1) : m;
    endfunction

    initial
    begin
        int               pick;
        logic [11:0]      whole;
        logic [RAW_W-1:0] word;

        // Zero, single fraction bits and the largest fraction
        queue_word(16'h0000, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h0008, 1'b0);
        queue_word(16'h000F, 1'b0);
        // Integer digit-count boundaries
        queue_word(16'h0010, 1'b0);
        queue_word(16'h0090, 1'b0);
        queue_word(16'h00A0, 1'b0);
        queue_word(16'h0630, 1'b0);
        queue_word(16'h0640, 1'b0);
        queue_word(16'h3E70, 1'b0);
        queue_word(16'h3E80, 1'b0);
        // Positive full scale
        queue_word(16'h7FF0, 1'b0);
        queue_word(16'h7FFF, 1'b0);
        // Most negative word, which negates onto itself, and the word just above it
        queue_word(16'h8000, 1'b0);
        queue_word(16'h8001, 1'b0);
        // Small negatives, some with a zero integer part, and two alternating bit patterns
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'hFFF8, 1'b0);
        queue_word(16'hFFF0, 1'b0);
        queue_word(16'hFF60, 1'b0);
        queue_word(16'h5555, 1'b0);
        queue_word(16'hAAAA, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3:
                    word = RAW_W'($urandom_range(0, 16'hFFFF));
                4, 5:
                    word = make_word(1'($urandom_range(0, 1)), 12'($urandom_range(0, 9)),
                                     4'($urandom_range(0, 15)));
                6:
                begin
                    // Land on either side of a digit-count step, or on the largest integer part
                    case ($urandom_range(0, 6))
                        0:       whole = 12'd9;
                        1:       whole = 12'd10;
                        2:       whole = 12'd99;
                        3:       whole = 12'd100;
                        4:       whole = 12'd999;
                        5:       whole = 12'd1000;
                        default: whole = 12'd2047;
                    endcase
                    word = make_word(1'($urandom_range(0, 1)), whole,
                                     4'($urandom_range(0, 15)));
                end
                7:
                begin
                    case ($urandom_range(0, 3))
                        0:       word = 16'h8000;
                        1:       word = 16'h7FFF;
                        2:       word = 16'hFFFF;
                        default: word = 16'h0000;
                    endcase
                end
                default:
                    word = make_word(1'($urandom_range(0, 1)), 12'($urandom_range(0, 2047)),
                                     4'($urandom_range(0, 15)));
            endcase
            // Drain all text before the random part and again midway
            queue_word(word, n == 0 || n == RANDOM_WORDS / 2);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the sender, then for the text, then let the block settle
        while (pending_words.size() != 0 || drv_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d temperature words (%0d negative), %0d characters checked",
                 words_accepted, negative_words, chars_checked);
        $display("including full-scale words, digit-count steps, a long text hold-off and drains");
        if (fail_count == 0 && expected_chars.size() == 0)
            $display("PASS fixed_point_temperature_to_ascii");
        else
            $display("FAIL fixed_point_temperature_to_ascii");
        $finish;
    end

endmodule

// ----- files.f -----
sv/ftoa_pkg.sv
sv/ftoa_temp_if.sv
sv/ftoa_char_if.sv
sv/ftoa_front.sv
sv/ftoa_fifo.sv
sv/ftoa_back.sv
sv/fixed_point_temperature_to_ascii.sv
verif/fixed_point_temperature_to_ascii_tb.sv
